// ===== rtl/sttab_pkg.sv =====
// Shared types and constants for the software timer table.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package sttab_pkg;

  // Table size and index widths
  localparam int MAX_TIMERS = 8;
  localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W      = IDX_W + 1;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_SET  = 2'd0;
  localparam logic [1:0] MODE_KILL = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // Command payload
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  msg_id;
    logic [15:0] param;
    logic [15:0] period;
  } cmd_t;

  // Message payload
  typedef struct packed {
    logic [7:0]  out_msg_id;
    logic [15:0] out_param;
    logic        last;
  } msg_t;

  // Token that walks the cell row, one cell per cycle unless the row stalls
  typedef struct packed {
    logic             valid;
    logic [1:0]       op;
    logic [7:0]       id;
    logic [15:0]      param;
    logic [15:0]      period;
    logic             matched;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] hi_live;
  } tok_t;

  // Message raised by a cell or by an immediate set
  typedef struct packed {
    logic        valid;
    logic [7:0]  id;
    logic [15:0] param;
  } em_t;

  // End-of-pass slot load, broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       id;
    logic [15:0]      param;
    logic [15:0]      period;
  } wr_t;

endpackage

`default_nettype wire

// ===== rtl/sttab_cell.sv =====
// One timer slot of the table plus its stage of the token pipeline.
// Depends on sttab_pkg.
`default_nettype none

module sttab_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic [sttab_pkg::IDX_W-1:0] my_idx,
  input  logic [sttab_pkg::IDX_W-1:0] top_idx,
  input  sttab_pkg::wr_t          wr,
  input  sttab_pkg::tok_t         tok_in,
  output sttab_pkg::tok_t         tok_out,
  output sttab_pkg::em_t          em
);
  import sttab_pkg::*;

  logic [7:0]  slot_id, slot_id_next;
  logic [15:0] slot_param, slot_param_next;
  logic [15:0] remaining, remaining_next;
  logic [15:0] reload, reload_next;
  tok_t        tok_next;
  logic        live;
  logic        in_span;

  assign live    = (slot_id != 8'd0);
  assign in_span = (my_idx <= top_idx);

  // Apply the passing token to this slot
  always_comb begin
    slot_id_next    = slot_id;
    slot_param_next = slot_param;
    remaining_next  = remaining;
    reload_next     = reload;
    tok_next        = tok_in;
    em              = '0;

    if (tok_in.valid) begin
      case (tok_in.op)
        MODE_SET: begin
          // Remember the highest free slot, reload the first match
          if (in_span && !tok_in.matched) begin
            if (!live) begin
              tok_next.free_found = 1'b1;
              tok_next.free_idx   = my_idx;
            end else if (slot_id == tok_in.id) begin
              slot_param_next  = tok_in.param;
              remaining_next   = tok_in.period;
              reload_next      = tok_in.period;
              tok_next.matched = 1'b1;
            end
          end
        end
        MODE_KILL: begin
          // Free a match, track the highest slot still in use
          if (slot_id == tok_in.id) begin
            slot_id_next = 8'd0;
          end else if (live) begin
            tok_next.hi_live = my_idx;
          end
        end
        MODE_TICK: begin
          // Count down, or fire and reload
          if (in_span && live) begin
            if (remaining != 16'd0) begin
              remaining_next = remaining - 16'd1;
            end else begin
              em.valid       = 1'b1;
              em.id          = slot_id;
              em.param       = slot_param;
              remaining_next = reload;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Load a free slot picked at the end of a set pass
    if (wr.en && (wr.idx == my_idx)) begin
      slot_id_next    = wr.id;
      slot_param_next = wr.param;
      remaining_next  = wr.period;
      reload_next     = wr.period;
    end
  end

  // Hold slot state and the token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_id       <= 8'd0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      slot_id <= slot_id_next;
      tok_out <= tok_next;
    end
    if (advance) begin
      slot_param <= slot_param_next;
      remaining  <= remaining_next;
      reload     <= reload_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sttab_emit.sv =====
// Message output stage: one pending message to resolve the last flag,
// and the output register. Depends on sttab_pkg.
`default_nettype none

module sttab_emit (
  input  logic            clk,
  input  logic            rst,
  input  sttab_pkg::em_t  em,
  input  sttab_pkg::em_t  imm,
  input  logic            fin,
  output logic            stall,
  output logic            msg_valid,
  input  logic            msg_ready,
  output sttab_pkg::msg_t msg
);
  import sttab_pkg::*;

  em_t  pend;
  logic out_free;
  logic push_mid;
  logic push_end;

  assign out_free = !msg_valid || msg_ready;
  assign push_mid = em.valid && pend.valid;
  assign push_end = fin && pend.valid;
  assign stall    = (push_mid || push_end) && !out_free;

  // Hold the pending message and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
      msg_valid  <= 1'b0;
    end else begin
      if (!stall) begin
        if (em.valid) begin
          pend <= em;
        end else if (fin) begin
          pend.valid <= 1'b0;
        end
      end

      if (imm.valid) begin
        msg_valid <= 1'b1;
        msg       <= '{out_msg_id: imm.id, out_param: imm.param, last: 1'b1};
      end else if ((push_mid || push_end) && out_free) begin
        msg_valid <= 1'b1;
        msg       <= '{out_msg_id: pend.id, out_param: pend.param, last: push_end};
      end else if (msg_ready) begin
        msg_valid <= 1'b0;
      end
    end
  end

  // Immediate set lands only in an empty or draining output register
  a_imm_free: assert property (@(posedge clk) disable iff (rst)
    imm.valid |-> out_free && !pend.valid)
    else $error("immediate message with output stage occupied");

  // A message firing and the end of a pass never overlap
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(em.valid && fin))
    else $error("message and end of pass in the same cycle");

  // The pending message is drained by the end of the pass
  a_pend_drain: assert property (@(posedge clk) disable iff (rst)
    (fin && !stall) |=> !pend.valid)
    else $error("pending message left after end of pass");

endmodule

`default_nettype wire

// ===== rtl/software_timer_table_top.sv =====
// Top level of the software timer table: command decode, cell row,
// end-of-pass update and output stage. Depends on sttab_pkg, sttab_cell, sttab_emit.
//
//   channel | signals                      | payload
//   --------+------------------------------+------------------------------------
//   command | cmd_valid, cmd_ready, cmd    | mode, msg_id, param, period
//   message | msg_valid, msg_ready, msg    | out_msg_id, out_param, last
//
// A set, kill or tick walks a token down the row of MAX_TIMERS cells, one
// cell per cycle while no stall occurs, then the end-of-pass update is made;
// the next command is taken only after that update.
// Ignored commands and a set with period 0 launch no token and leave busy clear.
// Reset frees all slots at once; no clearing pass is needed.
// A stalled message output freezes the row until the message is taken.
`default_nettype none

module software_timer_table_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  sttab_pkg::cmd_t cmd,
  output logic            msg_valid,
  input  logic            msg_ready,
  output sttab_pkg::msg_t msg
);
  import sttab_pkg::*;

  tok_t             head;
  tok_t             tok [MAX_TIMERS+1];
  em_t              em_cell [MAX_TIMERS];
  em_t              em_any;
  em_t              imm;
  wr_t              wr;
  tok_t             tail;
  logic [IDX_W-1:0] top_idx;
  logic             busy;
  logic             stall;
  logic             advance;
  logic             accept;
  logic             inject;
  logic             fin;
  logic             done;
  logic [CNT_W-1:0] slot;
  logic             slot_ok;
  logic [MAX_TIMERS:0] tok_vld;

  // Command decode
  assign cmd_ready = !busy && (!msg_valid || msg_ready);
  assign accept    = cmd_valid && cmd_ready;
  assign inject    = accept &&
                     (((cmd.mode == MODE_SET) && (cmd.msg_id != 8'd0) && (cmd.period != 16'd0)) ||
                      ((cmd.mode == MODE_KILL) && (cmd.msg_id != 8'd0)) ||
                      (cmd.mode == MODE_TICK));

  always_comb begin
    imm.valid = accept && (cmd.mode == MODE_SET) && (cmd.msg_id != 8'd0) &&
                (cmd.period == 16'd0);
    imm.id    = cmd.msg_id;
    imm.param = cmd.param;
  end

  assign advance = !stall;

  // Launch the token into the row
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (inject) begin
      head <= '{valid: 1'b1, op: cmd.mode, id: cmd.msg_id, param: cmd.param,
                period: cmd.period, matched: 1'b0, free_found: 1'b0,
                free_idx: '0, hi_live: '0};
    end else if (advance) begin
      head.valid <= 1'b0;
    end
  end

  // Cell row
  assign tok[0] = head;

  for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
    sttab_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .my_idx  (IDX_W'(g)),
      .top_idx (top_idx),
      .wr      (wr),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1]),
      .em      (em_cell[g])
    );
  end

  // Merge cell messages; only the cell holding the token can fire
  always_comb begin
    em_any = '0;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      em_any = em_any | em_cell[i];
    end
  end

  // End of pass
  assign tail    = tok[MAX_TIMERS];
  assign fin     = tail.valid;
  assign done    = fin && advance;
  assign slot    = tail.free_found ? {1'b0, tail.free_idx} : ({1'b0, top_idx} + CNT_W'(1));
  assign slot_ok = (slot < CNT_W'(MAX_TIMERS));

  always_comb begin
    wr.en     = done && (tail.op == MODE_SET) && !tail.matched && slot_ok;
    wr.idx    = slot[IDX_W-1:0];
    wr.id     = tail.id;
    wr.param  = tail.param;
    wr.period = tail.period;
  end

  // Track the used span and the busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      top_idx <= '0;
      busy    <= 1'b0;
    end else begin
      if (inject) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done && (tail.op == MODE_KILL)) begin
        top_idx <= tail.hi_live;
      end else if (wr.en && (slot > {1'b0, top_idx})) begin
        top_idx <= slot[IDX_W-1:0];
      end
    end
  end

  // Output stage
  sttab_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .em        (em_any),
    .imm       (imm),
    .fin       (fin),
    .stall     (stall),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg)
  );

  always_comb begin
    for (int i = 0; i <= MAX_TIMERS; i++) begin
      tok_vld[i] = tok[i].valid;
    end
  end

  // At most one token in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_vld) <= 1)
    else $error("more than one token in the cell row");

  // Idle means the row is empty
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (tok_vld == '0))
    else $error("token in the row while idle");

  // Busy ends only through an end-of-pass transfer
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy cleared without end of pass");

  // A slot load follows only an unmatched set
  a_wr_set: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (tail.op == MODE_SET) && !tail.matched && tail.valid)
    else $error("slot load outside an unmatched set");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for software_timer_table_top: set, kill and tick commands.
// A shadow timer table predicts the emitted messages. Depends on sttab_pkg and the RTL.

module tb;
  import sttab_pkg::*;

  // Mode 3 has no meaning; the block must drop it
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int         MAX_SHOWN = 30;

  logic clk;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd       = '0;
  logic msg_valid;
  logic msg_ready = 1'b0;
  msg_t msg;
  // High during the stretch where neither side idles
  bit   steady    = 1'b0;

  software_timer_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg)
  );

  // Shadow copy of the timer table and the queue of messages it has emitted
  class timer_shadow;
    msg_t        due_msgs[$];
    logic [7:0]  slot_id[MAX_TIMERS];
    logic [15:0] slot_par[MAX_TIMERS];
    logic [15:0] slot_cnt[MAX_TIMERS];
    logic [15:0] slot_per[MAX_TIMERS];
    int          top;
    int          errors;
    int          cmds_seen;
    int          msgs_seen;

    function new();
      foreach (slot_id[i]) begin
        slot_id[i]  = '0;
        slot_par[i] = '0;
        slot_cnt[i] = '0;
        slot_per[i] = '0;
      end
      top       = 0;
      errors    = 0;
      cmds_seen = 0;
      msgs_seen = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_SHOWN) $display("%0t ERROR: %s", $realtime, what);
    endtask

    function void load(int i, cmd_t c);
      slot_id[i]  = c.msg_id;
      slot_par[i] = c.param;
      slot_cnt[i] = c.period;
      slot_per[i] = c.period;
    endfunction

    // Update the table for one accepted command and queue what it emits
    function void take_cmd(cmd_t c);
      msg_t m;
      msg_t burst[$];
      int   free_idx;
      bit   hit;
      cmds_seen++;
      case (c.mode)
        MODE_SET: begin
          if (c.msg_id != 0) begin
            if (c.period == 0) begin
              m.out_msg_id = c.msg_id;
              m.out_param  = c.param;
              m.last       = 1'b1;
              due_msgs.push_back(m);
            end else begin
              // Reload a matching slot, else take the highest free one in the span
              free_idx = top + 1;
              hit      = 1'b0;
              for (int i = 0; i <= top; i++) begin
                if (slot_id[i] == 0) begin
                  free_idx = i;
                end else if (slot_id[i] == c.msg_id) begin
                  load(i, c);
                  hit = 1'b1;
                  break;
                end
              end
              if (!hit && free_idx < MAX_TIMERS) begin
                load(free_idx, c);
                if (free_idx > top) top = free_idx;
              end
            end
          end
        end
        MODE_KILL: begin
          if (c.msg_id != 0) begin
            foreach (slot_id[i]) if (slot_id[i] == c.msg_id) slot_id[i] = '0;
            while (top > 0 && slot_id[top] == 0) top--;
          end
        end
        MODE_TICK: begin
          for (int i = 0; i <= top; i++) begin
            if (slot_id[i] != 0) begin
              if (slot_cnt[i] > 0) begin
                slot_cnt[i] = slot_cnt[i] - 16'd1;
              end else begin
                m.out_msg_id = slot_id[i];
                m.out_param  = slot_par[i];
                m.last       = 1'b0;
                burst.push_back(m);
                slot_cnt[i]  = slot_per[i];
              end
            end
          end
          if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
          foreach (burst[i]) due_msgs.push_back(burst[i]);
        end
        default: ;
      endcase
    endfunction

    // Compare one message transfer with the oldest due message
    task match_msg(msg_t got);
      msg_t want;
      msgs_seen++;
      if (due_msgs.size() == 0) begin
        report($sformatf("unexpected message id=%0d param=%h last=%b",
                         got.out_msg_id, got.out_param, got.last));
      end else begin
        want = due_msgs.pop_front();
        if (got.out_msg_id !== want.out_msg_id)
          report($sformatf("out_msg_id %0d, want %0d", got.out_msg_id, want.out_msg_id));
        if (got.out_param !== want.out_param)
          report($sformatf("out_param %h, want %h (id %0d)",
                           got.out_param, want.out_param, want.out_msg_id));
        if (got.last !== want.last)
          report($sformatf("last %b, want %b (id %0d)", got.last, want.last,
                           want.out_msg_id));
      end
    endtask

    task flush();
      while (due_msgs.size() > 0) begin
        report($sformatf("message id=%0d never arrived", due_msgs[0].out_msg_id));
        void'(due_msgs.pop_front());
      end
    endtask
  endclass

  timer_shadow shadow = new();

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the message side about 12 percent of the time, except in the steady stretch
  always @(posedge clk) begin
    msg_ready <= steady || ($urandom_range(99) >= 12);
  end

  // Note command transfers before checking messages at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) shadow.take_cmd(cmd);
      if (msg_valid && msg_ready) shadow.match_msg(msg);
    end
  end

  // Present one command and hold it until the transfer
  task send_cmd(logic [1:0] mode, logic [7:0] id, logic [15:0] par, logic [15:0] per);
    if (!steady && $urandom_range(99) < 12) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd       <= '{mode: mode, msg_id: id, param: par, period: per};
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  task send_tick();
    send_cmd(MODE_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Mostly a small pool so sets match and kills hit; sometimes any id or zero
  function automatic logic [7:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 8'd0;
    if (r < 14) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(1, 12));
  endfunction

  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 16'd0;
    if (r < 85) return 16'($urandom_range(1, 6));
    if (r < 95) return 16'($urandom_range(7, 40));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Directed part, then random traffic
  initial begin
    int         counted;
    int         r;
    logic [1:0] mode;
    logic [7:0] id;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, ignored commands, immediate sends at the field extremes
    send_tick();
    send_cmd(MODE_SET, 8'd0, 16'h5555, 16'd5);
    send_cmd(MODE_KILL, 8'd0, 16'hFFFF, 16'hFFFF);
    send_cmd(MODE_NONE, 8'd3, 16'hAAAA, 16'd2);
    send_cmd(MODE_SET, 8'd255, 16'hFFFF, 16'd0);
    send_cmd(MODE_SET, 8'd1, 16'h0000, 16'd0);
    // Fill every slot, the last with the longest period
    for (int i = 1; i <= MAX_TIMERS; i++)
      send_cmd(MODE_SET, 8'(i), (i % 2) ? 16'h0000 : 16'hFFFF,
               (i == MAX_TIMERS) ? 16'hFFFF : 16'(i - 1 + (i == 1)));
    // Table full: dropped
    send_cmd(MODE_SET, 8'd9, 16'h0F0F, 16'd3);
    // Reload a live timer
    send_cmd(MODE_SET, 8'd2, 16'h1234, 16'd1);
    send_tick();
    send_tick();
    // Free the top slot and one inside the span, then refill the hole
    send_cmd(MODE_KILL, 8'(MAX_TIMERS), 16'd0, 16'd0);
    send_cmd(MODE_KILL, 8'd5, 16'd0, 16'd0);
    send_cmd(MODE_SET, 8'd10, 16'hBEEF, 16'd1);
    send_tick();
    send_tick();
    send_cmd(MODE_KILL, 8'd1, 16'd0, 16'd0);

    // Random part; ignored commands do not count
    counted = 0;
    while (counted < 125) begin
      steady = (counted >= 60 && counted < 100);
      r      = $urandom_range(99);
      id     = pick_id();
      if (r < 36) mode = MODE_SET;
      else if (r < 48) mode = MODE_KILL;
      else if (r < 97) mode = MODE_TICK;
      else mode = MODE_NONE;
      if (mode == MODE_TICK) send_tick();
      else send_cmd(mode, id, 16'($urandom), pick_period());
      if (mode == MODE_TICK || (mode != MODE_NONE && id != 0)) counted++;
    end
    steady = 1'b0;
    cmd_valid <= 1'b0;
    // Let the monitor note the final command transfer first
    @(posedge clk);

    // Drain, then wait out more than one full pass for anything stray
    while (shadow.due_msgs.size() != 0) @(posedge clk);
    repeat (3 * MAX_TIMERS) @(posedge clk);
    shadow.flush();
    $display("Covered %0d command transfers and %0d message transfers, %0d errors.",
             shadow.cmds_seen, shadow.msgs_seen, shadow.errors);
    if (shadow.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #(2_000_000);
    $display("Timeout with %0d messages outstanding.", shadow.due_msgs.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== software_timer_table_top.f =====
rtl/sttab_pkg.sv
rtl/sttab_cell.sv
rtl/sttab_emit.sv
rtl/software_timer_table_top.sv
tb/tb.sv
